// ===== rtl/plane_crossing_section_defines.svh =====
// Assertion macros for the plane crossing section block.
`ifndef PLANE_CROSSING_SECTION_DEFINES_SVH
`define PLANE_CROSSING_SECTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plane crossing section: assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plane crossing section: assertion failed");

`endif

// ===== rtl/pcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int DIM       = 8;
  localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int LEN_W     = 6;
  localparam int CI_W      = 5;
  localparam int DATA_W    = 32;
  localparam int T_W       = 31;
  localparam int PROD_W    = DATA_W + T_W;
  localparam int STEP_W    = $clog2(T_W + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COORD_INDEX    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_POSITION = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_POSITIVE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_NEGATIVE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH  = CFG_IDX_W'(4);

  localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET = LEN_W'(8);
  localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(1) << (T_W - 1);

  typedef struct packed {
    logic accept;
    logic rd_coord;
    logic classify;
    logic rd_elem;
    logic mul;
    logic round;
    logic load_out;
    logic next_elem;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic complete;
    logic copy;
    logic interp;
    logic div_done;
    logic last_elem;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/pcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcs_pkg::DATA_W-1:0] num,
  input  logic [pcs_pkg::DATA_W-1:0] den,
  output logic                       done,
  output logic [pcs_pkg::T_W-1:0]    quot
);

  import pcs_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den_r;
  logic [STEP_W-1:0] steps;
  logic              running;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;

  // restoring division of num * 2^T_W by den, one quotient bit a cycle
  always_comb begin
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(T_W);
      end else if (running) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quot  <= '0;
    end else if (running) begin
      rem  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quot <= {quot[T_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcs_pkg::DATA_W-1:0]        cfg_data,
  input  logic signed [pcs_pkg::DATA_W-1:0] sample,
  input  pcs_pkg::ctrl_cmd_t                cmd,
  output pcs_pkg::ctrl_status_t             status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [pcs_pkg::DATA_W-1:0] section_value,
  output logic                              last_of_vector
);

  import pcs_pkg::*;

  logic [CI_W-1:0]          coord_index;
  logic signed [DATA_W-1:0] plane_position;
  logic                     count_positive;
  logic                     count_negative;
  logic [LEN_W-1:0]         vector_length;

  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         ci_full;
  logic [IDX_W-1:0]         coord_sel;
  logic                     two_sided;

  logic [IDX_W-1:0]         elem_count;
  logic [IDX_W-1:0]         elem_idx;
  logic                     bank;
  logic                     armed;
  logic                     copy_mode;

  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  logic [DATA_W-1:0]        rd0;
  logic [DATA_W-1:0]        rd1;
  logic signed [DATA_W-1:0] cur_d;
  logic signed [DATA_W-1:0] prev_d;

  logic                     cur_below;
  logic                     cur_on;
  logic                     prev_below;
  logic                     prev_on;
  logic                     side_change;

  logic signed [DATA_W:0]   diff_n;
  logic signed [DATA_W:0]   neg_n;
  logic signed [DATA_W:0]   diff_d;
  logic signed [DATA_W:0]   neg_d;
  logic [DATA_W-1:0]        num;
  logic [DATA_W-1:0]        den;
  logic                     div_start;
  logic                     div_done;
  logic [T_W-1:0]           t;

  logic signed [DATA_W:0]   diff_e;
  logic signed [DATA_W:0]   neg_e;
  logic [DATA_W-1:0]        mag;
  logic [PROD_W-1:0]        prod;
  logic signed [DATA_W-1:0] a_reg;
  logic signed [DATA_W-1:0] b_reg;
  logic                     neg;
  logic [PROD_W:0]          rnd_sum;
  logic [DATA_W-1:0]        r;
  logic signed [DATA_W:0]   res_sum;
  logic signed [DATA_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_index    <= '0;
      plane_position <= '0;
      count_positive <= 1'b1;
      count_negative <= 1'b0;
      vector_length  <= VECTOR_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COORD_INDEX:    coord_index    <= cfg_data[CI_W-1:0];
        REG_PLANE_POSITION: plane_position <= cfg_data;
        REG_COUNT_POSITIVE: count_positive <= cfg_data[0];
        REG_COUNT_NEGATIVE: count_negative <= cfg_data[0];
        REG_VECTOR_LENGTH:  vector_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (vector_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (vector_length > LEN_W'(DIM)) begin
      len_eff = LEN_W'(DIM);
    end else begin
      len_eff = vector_length;
    end
    ci_full   = (LEN_W'(coord_index) < len_eff) ? LEN_W'(coord_index)
                                                : len_eff - LEN_W'(1);
    coord_sel = ci_full[IDX_W-1:0];
    two_sided = count_positive & count_negative;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      elem_idx   <= '0;
      bank       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        elem_count <= status.complete ? '0 : elem_count + IDX_W'(1);
      end
      if (cmd.finish) begin
        elem_idx <= '0;
        bank     <= ~bank;
      end else if (cmd.next_elem) begin
        elem_idx <= elem_idx + IDX_W'(1);
      end
    end
  end

  assign rd_addr = cmd.rd_coord ? coord_sel : elem_idx;
  assign rd_en   = cmd.rd_coord | cmd.rd_elem;

  pcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DIM)
  ) u_ram0 (
    .clk   (clk),
    .we    (cmd.accept & ~bank),
    .waddr (elem_count),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd0)
  );

  pcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DIM)
  ) u_ram1 (
    .clk   (clk),
    .we    (cmd.accept & bank),
    .waddr (elem_count),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd1)
  );

  always_comb begin
    cur_d       = bank ? rd1 : rd0;
    prev_d      = bank ? rd0 : rd1;
    cur_below   = (cur_d < plane_position);
    cur_on      = (cur_d == plane_position);
    prev_below  = (prev_d < plane_position);
    prev_on     = (prev_d == plane_position);
    side_change = (cur_below != prev_below) || (cur_on != prev_on);

    diff_n = {plane_position[DATA_W-1], plane_position} - {prev_d[DATA_W-1], prev_d};
    neg_n  = -diff_n;
    num    = diff_n[DATA_W] ? neg_n[DATA_W-1:0] : diff_n[DATA_W-1:0];
    diff_d = {cur_d[DATA_W-1], cur_d} - {prev_d[DATA_W-1], prev_d};
    neg_d  = -diff_d;
    den    = diff_d[DATA_W] ? neg_d[DATA_W-1:0] : diff_d[DATA_W-1:0];
  end

  assign div_start = cmd.classify & status.interp;

  pcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (cmd.classify) begin
      priority if (armed) begin
        if (cur_on) begin
          armed <= two_sided;
        end else if (side_change && !two_sided) begin
          armed <= 1'b0;
        end
      end else if (two_sided) begin
        armed <= 1'b1;
      end else if ((count_positive || count_negative) && !cur_on) begin
        armed <= count_positive ? cur_below : ~cur_below;
      end else begin
        armed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      copy_mode <= cur_on;
    end
  end

  always_comb begin
    diff_e  = {cur_d[DATA_W-1], cur_d} - {prev_d[DATA_W-1], prev_d};
    neg_e   = -diff_e;
    mag     = diff_e[DATA_W] ? neg_e[DATA_W-1:0] : diff_e[DATA_W-1:0];
    rnd_sum = {1'b0, prod} + ROUND_HALF;
    res_sum = neg ? ({a_reg[DATA_W-1], a_reg} - {1'b0, r})
                  : ({a_reg[DATA_W-1], a_reg} + {1'b0, r});
    out_value = copy_mode ? b_reg : res_sum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod  <= PROD_W'(mag) * PROD_W'(t);
      a_reg <= prev_d;
      b_reg <= cur_d;
      neg   <= diff_e[DATA_W];
    end
    if (cmd.round) begin
      r <= rnd_sum[T_W +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      section_value  <= out_value;
      last_of_vector <= status.last_elem;
    end
  end

  always_comb begin
    status.complete  = ((LEN_W'(elem_count) + LEN_W'(1)) >= len_eff);
    status.copy      = armed & cur_on;
    status.interp    = armed & ~cur_on & side_change;
    status.div_done  = div_done;
    status.last_elem = (LEN_W'(elem_idx) == (len_eff - LEN_W'(1)));
    status.out_free  = ~out_valid | out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/pcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcs_pkg::ctrl_status_t status,
  output pcs_pkg::ctrl_cmd_t    cmd
);

  import pcs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COORD = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_ROUND = 3'd6;
  localparam logic [2:0] S_LOAD  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.complete) begin
          state_next = S_COORD;
        end
      end
      S_COORD: begin
        cmd.rd_coord = 1'b1;
        state_next   = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        priority if (status.copy) begin
          state_next = S_READ;
        end else if (status.interp) begin
          state_next = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_elem = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.last_elem) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next_elem = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/plane_crossing_section.sv =====
// Elements that do not complete a vector are taken one per cycle.
// A completing element starts classification: with no crossing the block
// returns to idle; an on-plane vector is copied and a crossing goes first
// through the one-bit-a-cycle divider, then the read-multiply-round-load
// loop per element, held by output stalls. Synchronous reset clears control
// state and loads the register defaults; vector memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "plane_crossing_section_defines.svh"

module plane_crossing_section (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcs_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pcs_pkg::DATA_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pcs_pkg::DATA_W-1:0] section_value,
  output logic                              last_of_vector
);

  import pcs_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pcs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .section_value  (section_value),
    .last_of_vector (last_of_vector)
  );

  `PCS_ASSERT_IMPLY(a_load_into_free_slot, cmd.load_out, status.out_free)
  `PCS_ASSERT_NEXT(a_emission_holds_input, cmd.classify && (status.copy || status.interp), !in_ready)
  `PCS_ASSERT_IMPLY(a_result_from_load, $rose(out_valid), $past(cmd.load_out))

endmodule

`default_nettype wire
